/* hw/rtl/hars_pkg.sv */
// hars_pkg: shared types, constants and arithmetic helpers for the hit alignment core
// used by hars_lut, hars_rot and hit_alignment_rotate_shift_core; no dependencies
`timescale 1ns / 1ps

package hars_pkg;

    // sizes
    localparam int SENSOR_ENTRIES_DEF = 256;
    localparam int WORDS_PER_SENSOR   = 12;
    localparam int POS_WIDTH          = 32;
    localparam int FRAC_BITS          = 16;
    localparam int WORD_W             = 32;
    localparam int COORD_W            = 33;
    localparam int PROD_W             = COORD_W + WORD_W;
    localparam int RND_W              = PROD_W - FRAC_BITS + 1;
    localparam int SUM_W              = RND_W + 1;
    localparam int FIN_W              = COORD_W + 2;

    // item modes
    localparam logic MODE_HIT  = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // table word indexes
    localparam logic [3:0] SEL_CX = 4'd0;
    localparam logic [3:0] SEL_CY = 4'd1;
    localparam logic [3:0] SEL_CZ = 4'd2;
    localparam logic [3:0] SEL_CA = 4'd3;
    localparam logic [3:0] SEL_SA = 4'd4;
    localparam logic [3:0] SEL_CB = 4'd5;
    localparam logic [3:0] SEL_SB = 4'd6;
    localparam logic [3:0] SEL_CG = 4'd7;
    localparam logic [3:0] SEL_SG = 4'd8;
    localparam logic [3:0] SEL_OX = 4'd9;
    localparam logic [3:0] SEL_OY = 4'd10;
    localparam logic [3:0] SEL_OZ = 4'd11;

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [RND_W-1:0]   rnd_t;

    typedef struct packed {
        logic              mode;
        logic [7:0]        sensor_id;
        logic [3:0]        param_select;
        logic signed [31:0] param_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } hars_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               aligned;
        logic               saturated;
    } hars_out_t;

    // one sensor's constant set
    typedef struct packed {
        word_t cx, cy, cz;
        word_t ca, sa, cb, sb, cg, sg;
        word_t ox, oy, oz;
    } consts_t;

    // data that rides along the rotation stages
    typedef struct packed {
        logic    aligned;
        logic    sat;
        word_t   px, py, pz;
        consts_t k;
    } side_t;

    // round half up and drop the fraction bits
    function automatic rnd_t round_frac(input prod_t p);
        logic signed [PROD_W:0] t;
        t = {p[PROD_W-1], p} + (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1));
        return rnd_t'(t[PROD_W:FRAC_BITS]);
    endfunction

endpackage

/* hw/rtl/hars_lut.sv */
// hars_lut: per-sensor constant table (12 banks) and sensor valid bits
// depends on hars_pkg
`timescale 1ns / 1ps

module hars_lut #(
    parameter int SENSOR_ENTRIES = hars_pkg::SENSOR_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  hars_pkg::hars_in_t item,
    output hars_pkg::consts_t  k,
    output logic               known
);
    import hars_pkg::*;

    localparam int IDX_W = (SENSOR_ENTRIES > 1) ? $clog2(SENSOR_ENTRIES) : 1;
    localparam int AW    = (IDX_W > 8) ? IDX_W : 8;

    logic [AW-1:0]             sid_wide;
    logic [IDX_W-1:0]          idx;
    logic                      in_range;
    logic                      wr;
    logic                      rd;
    logic [SENSOR_ENTRIES-1:0] valid_reg;
    logic                      known_reg;
    word_t                     rd_reg [WORDS_PER_SENSOR];

    // address decode
    assign sid_wide = AW'(item.sensor_id);
    assign idx      = sid_wide[IDX_W-1:0];
    assign in_range = (32'(item.sensor_id) < 32'(SENSOR_ENTRIES));
    assign wr = take && (item.mode == MODE_LOAD) && in_range
                && (32'(item.param_select) < 32'(WORDS_PER_SENSOR));
    assign rd = take && (item.mode == MODE_HIT);

    // one bank per word index, registered read
    for (genvar g = 0; g < WORDS_PER_SENSOR; g++) begin : g_bank
        word_t bank [SENSOR_ENTRIES];
        always_ff @(posedge clk)
        begin
            if (wr && (item.param_select == 4'(g)))
            begin
                bank[idx] <= item.param_value;
            end
            if (rd)
            begin
                rd_reg[g] <= bank[idx];
            end
        end
    end

    // sensor valid bits and lookup flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            known_reg <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (rd)
            begin
                known_reg <= in_range && valid_reg[idx];
            end
        end
    end

    assign known = known_reg;
    assign k.cx  = rd_reg[SEL_CX];
    assign k.cy  = rd_reg[SEL_CY];
    assign k.cz  = rd_reg[SEL_CZ];
    assign k.ca  = rd_reg[SEL_CA];
    assign k.sa  = rd_reg[SEL_SA];
    assign k.cb  = rd_reg[SEL_CB];
    assign k.sb  = rd_reg[SEL_SB];
    assign k.cg  = rd_reg[SEL_CG];
    assign k.sg  = rd_reg[SEL_SG];
    assign k.ox  = rd_reg[SEL_OX];
    assign k.oy  = rd_reg[SEL_OY];
    assign k.oz  = rd_reg[SEL_OZ];

endmodule

/* hw/rtl/hars_rot.sv */
// hars_rot: one plane rotation, na = c*a + s*b, nb = c*b - s*a, two stages
// depends on hars_pkg
`timescale 1ns / 1ps

module hars_rot (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  hars_pkg::coord_t a,
    input  hars_pkg::coord_t b,
    input  hars_pkg::coord_t t_in,
    input  hars_pkg::word_t  c,
    input  hars_pkg::word_t  s,
    input  hars_pkg::side_t  side_in,
    output logic            vld_out,
    output hars_pkg::coord_t na,
    output hars_pkg::coord_t nb,
    output hars_pkg::coord_t t_out,
    output hars_pkg::side_t  side_out
);
    import hars_pkg::*;

    localparam logic signed [SUM_W-1:0] MID_HI = SUM_W'({1'b0, {(COORD_W - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] MID_LO = -MID_HI;

    logic  vld1_reg, vld2_reg;
    prod_t p_ac_reg, p_bs_reg, p_bc_reg, p_as_reg;
    coord_t t1_reg, t2_reg, na_reg, nb_reg;
    side_t side1_reg, side2_reg;
    side_t side_next;
    logic signed [SUM_W-1:0] sum_a, sum_b;
    coord_t na_next, nb_next;
    logic   sat_next;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ac_reg  <= PROD_W'(a) * PROD_W'(c);
            p_bs_reg  <= PROD_W'(b) * PROD_W'(s);
            p_bc_reg  <= PROD_W'(b) * PROD_W'(c);
            p_as_reg  <= PROD_W'(a) * PROD_W'(s);
            t1_reg    <= t_in;
            side1_reg <= side_in;
        end
    end

    // stage 2: round, combine and clip
    always_comb
    begin
        sum_a    = SUM_W'(round_frac(p_ac_reg)) + SUM_W'(round_frac(p_bs_reg));
        sum_b    = SUM_W'(round_frac(p_bc_reg)) - SUM_W'(round_frac(p_as_reg));
        sat_next = 1'b0;
        if (sum_a > MID_HI)
        begin
            na_next  = COORD_W'(MID_HI);
            sat_next = 1'b1;
        end
        else if (sum_a < MID_LO)
        begin
            na_next  = COORD_W'(MID_LO);
            sat_next = 1'b1;
        end
        else
        begin
            na_next = COORD_W'(sum_a);
        end
        if (sum_b > MID_HI)
        begin
            nb_next  = COORD_W'(MID_HI);
            sat_next = 1'b1;
        end
        else if (sum_b < MID_LO)
        begin
            nb_next  = COORD_W'(MID_LO);
            sat_next = 1'b1;
        end
        else
        begin
            nb_next = COORD_W'(sum_b);
        end
        side_next     = side1_reg;
        side_next.sat = side1_reg.sat | sat_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            t2_reg    <= t1_reg;
            side2_reg <= side_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    assign vld_out  = vld2_reg;
    assign na       = na_reg;
    assign nb       = nb_reg;
    assign t_out    = t2_reg;
    assign side_out = side2_reg;

endmodule

/* hw/rtl/hit_alignment_rotate_shift_core.sv */
// hit_alignment_rotate_shift_core: top level, table lookup, three rotations, final shift
// depends on hars_pkg, hars_lut, hars_rot
`timescale 1ns / 1ps

// Usage
// One input channel (item_valid / item_stall / item) carries two kinds of transfer:
// mode load with a select below 12 writes one constant word for one sensor and marks
// the sensor valid, and gives no result; mode hit gives exactly one result transfer on
// the output channel (result_valid / result_stall / result) with the corrected position.
// Hits on a sensor never loaded come back unchanged with aligned low.
// Pipeline: an accepted hit passes through nine register stages: table read, centre
// subtract, three rotations of two stages each (multiply, then round and clip) and the
// final shift and clip.
// Throughput: one item per cycle while no result is stalled; every stage advances together.
// A load followed directly by a hit on the same sensor sees the new word.
// When the receiver stalls a presented result, the whole pipeline holds and item_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset clears all pipeline valid bits and all sensor valid bits; table words are
// undefined until loaded, and no clearing pass runs.

module hit_alignment_rotate_shift_core #(
    parameter int SENSOR_ENTRIES = hars_pkg::SENSOR_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hars_pkg::hars_in_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output hars_pkg::hars_out_t result
);
    import hars_pkg::*;

    localparam logic signed [FIN_W-1:0] POS_HI = FIN_W'({1'b0, {(POS_WIDTH - 1){1'b1}}});
    localparam logic signed [FIN_W-1:0] POS_LO = -POS_HI - FIN_W'(1);

    logic      en, take;
    consts_t   k1;
    logic      known1;
    logic      v1_reg, v2_reg, out_valid_reg;
    word_t     px1_reg, py1_reg, pz1_reg;
    coord_t    x2_reg, y2_reg, z2_reg;
    side_t     side2_reg;
    hars_out_t out_reg;
    hars_out_t out_next;

    logic   va, vb, vc;
    coord_t ya, za, xa, zb, xb, yb, xc, yc, zc;
    side_t  sa_s, sb_s, sc_s;

    logic signed [FIN_W-1:0] fx, fy, fz;
    logic                    fsat;

    // global advance: hold everything while the output transfer is stalled
    assign en         = !(out_valid_reg && result_stall);
    assign item_stall = !en;
    assign take       = item_valid && en;

    hars_lut #(
        .SENSOR_ENTRIES(SENSOR_ENTRIES)
    ) u_lut (
        .clk  (clk),
        .rst_n(rst_n),
        .take (take),
        .item (item),
        .k    (k1),
        .known(known1)
    );

    // stage 1: capture position beside the table read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px1_reg <= item.pos_x;
            py1_reg <= item.pos_y;
            pz1_reg <= item.pos_z;
        end
    end

    // stage 2: subtract the plane centre
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg            <= COORD_W'(px1_reg) - COORD_W'(k1.cx);
            y2_reg            <= COORD_W'(py1_reg) - COORD_W'(k1.cy);
            z2_reg            <= COORD_W'(pz1_reg) - COORD_W'(k1.cz);
            side2_reg.aligned <= known1;
            side2_reg.sat     <= 1'b0;
            side2_reg.px      <= px1_reg;
            side2_reg.py      <= py1_reg;
            side2_reg.pz      <= pz1_reg;
            side2_reg.k       <= k1;
        end
    end

    // rotation about x by -alpha
    hars_rot u_rot_x (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v2_reg),
        .a(y2_reg), .b(z2_reg), .t_in(x2_reg),
        .c(side2_reg.k.ca), .s(side2_reg.k.sa), .side_in(side2_reg),
        .vld_out(va), .na(ya), .nb(za), .t_out(xa), .side_out(sa_s)
    );

    // rotation about y by -beta
    hars_rot u_rot_y (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(va),
        .a(za), .b(xa), .t_in(ya),
        .c(sa_s.k.cb), .s(sa_s.k.sb), .side_in(sa_s),
        .vld_out(vb), .na(zb), .nb(xb), .t_out(yb), .side_out(sb_s)
    );

    // rotation about z by -gamma
    hars_rot u_rot_z (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vb),
        .a(xb), .b(yb), .t_in(zb),
        .c(sb_s.k.cg), .s(sb_s.k.sg), .side_in(sb_s),
        .vld_out(vc), .na(xc), .nb(yc), .t_out(zc), .side_out(sc_s)
    );

    // final shift, clip and pass-through select
    always_comb
    begin
        fx   = FIN_W'(xc) + FIN_W'(sc_s.k.cx) - FIN_W'(sc_s.k.ox);
        fy   = FIN_W'(yc) + FIN_W'(sc_s.k.cy) - FIN_W'(sc_s.k.oy);
        fz   = FIN_W'(zc) + FIN_W'(sc_s.k.cz) - FIN_W'(sc_s.k.oz);
        fsat = sc_s.sat;
        if (fx > POS_HI)
        begin
            fx = POS_HI;
            fsat = 1'b1;
        end
        else if (fx < POS_LO)
        begin
            fx = POS_LO;
            fsat = 1'b1;
        end
        if (fy > POS_HI)
        begin
            fy = POS_HI;
            fsat = 1'b1;
        end
        else if (fy < POS_LO)
        begin
            fy = POS_LO;
            fsat = 1'b1;
        end
        if (fz > POS_HI)
        begin
            fz = POS_HI;
            fsat = 1'b1;
        end
        else if (fz < POS_LO)
        begin
            fz = POS_LO;
            fsat = 1'b1;
        end
        if (sc_s.aligned)
        begin
            out_next.out_x     = 32'(fx);
            out_next.out_y     = 32'(fy);
            out_next.out_z     = 32'(fz);
            out_next.aligned   = 1'b1;
            out_next.saturated = fsat;
        end
        else
        begin
            out_next.out_x     = sc_s.px;
            out_next.out_y     = sc_s.py;
            out_next.out_z     = sc_s.pz;
            out_next.aligned   = 1'b0;
            out_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= take && (item.mode == MODE_HIT);
            v2_reg        <= v1_reg;
            out_valid_reg <= vc;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // a pass-through result never reports a clip
    a_unaligned_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.aligned) |-> !result.saturated)
        else $error("unaligned result flagged saturated");

    // a load transfer never enters the result pipeline
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.mode == MODE_LOAD) |=> !v1_reg)
        else $error("load transfer produced a pipeline valid");

    // stage valid bits hold while the output is stalled
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(vc)))
        else $error("pipeline moved during stall");

endmodule

/* sim/tb_hit_alignment_rotate_shift_core.sv */
// tb_hit_alignment_rotate_shift_core: self-checking bench for the hit alignment core
// depends on hars_pkg and hit_alignment_rotate_shift_core; predicts every hit in the bench
`timescale 1ns / 1ps

module tb_hit_alignment_rotate_shift_core;
    import hars_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 20;
    localparam longint MID_MAX = 64'sd4294967295;
    localparam longint POS_MAX = 64'sd2147483647;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    hars_in_t  item;
    logic      result_valid;
    logic      result_stall;
    hars_out_t result;

    // bench copy of the sensor table
    bit        known_sensor [256];
    word_t     const_words [256][12];

    hars_out_t hit_results_q [$];
    int        mismatch_count;
    int        cycle_count;
    int        sender_idle_pct;
    int        receiver_stall_pct;
    int        hold_off_left;

    hit_alignment_rotate_shift_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hit_alignment_rotate_shift_core test failed");
            $finish;
        end
    end

    // round-half-up product of a coordinate and a trig word
    function automatic longint mul_round(longint u, longint t);
        longint p;
        p = u * t + (64'sd1 <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, inout bit flag);
        if (v > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // corrected position of one hit from the current table
    function automatic hars_out_t align_hit(hars_in_t it);
        hars_out_t r;
        longint    k [12];
        longint    x, y, z, nx, ny, nz;
        bit        sat;
        r.out_x = it.pos_x;
        r.out_y = it.pos_y;
        r.out_z = it.pos_z;
        r.aligned = 1'b0;
        r.saturated = 1'b0;
        if (!known_sensor[it.sensor_id])
            return r;
        for (int i = 0; i < 12; i++)
            k[i] = const_words[it.sensor_id][i];
        sat = 1'b0;
        x = longint'(it.pos_x) - k[SEL_CX];
        y = longint'(it.pos_y) - k[SEL_CY];
        z = longint'(it.pos_z) - k[SEL_CZ];
        // rotate about x by -alpha
        ny = clamp(mul_round(y, k[SEL_CA]) + mul_round(z, k[SEL_SA]), -MID_MAX, MID_MAX, sat);
        nz = clamp(mul_round(z, k[SEL_CA]) - mul_round(y, k[SEL_SA]), -MID_MAX, MID_MAX, sat);
        y = ny;
        z = nz;
        // rotate about y by -beta
        nz = clamp(mul_round(z, k[SEL_CB]) + mul_round(x, k[SEL_SB]), -MID_MAX, MID_MAX, sat);
        nx = clamp(mul_round(x, k[SEL_CB]) - mul_round(z, k[SEL_SB]), -MID_MAX, MID_MAX, sat);
        x = nx;
        z = nz;
        // rotate about z by -gamma
        nx = clamp(mul_round(x, k[SEL_CG]) + mul_round(y, k[SEL_SG]), -MID_MAX, MID_MAX, sat);
        ny = clamp(mul_round(y, k[SEL_CG]) - mul_round(x, k[SEL_SG]), -MID_MAX, MID_MAX, sat);
        x = nx;
        y = ny;
        // shift back and clip to the output range
        r.out_x = 32'(clamp(x + k[SEL_CX] - k[SEL_OX], -POS_MAX - 1, POS_MAX, sat));
        r.out_y = 32'(clamp(y + k[SEL_CY] - k[SEL_OY], -POS_MAX - 1, POS_MAX, sat));
        r.out_z = 32'(clamp(z + k[SEL_CZ] - k[SEL_OZ], -POS_MAX - 1, POS_MAX, sat));
        r.aligned = 1'b1;
        r.saturated = sat;
        return r;
    endfunction

    // one item offered until its transfer, then the table or the result queue updated
    task automatic send_item(hars_in_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        if (it.mode == MODE_LOAD)
        begin
            if (it.param_select <= SEL_OZ)
            begin
                const_words[it.sensor_id][it.param_select] = it.param_value;
                known_sensor[it.sensor_id] = 1'b1;
            end
        end
        else
            hit_results_q = {hit_results_q, align_hit(it)};
    endtask

    task automatic send_hit(logic [7:0] sid, word_t px, word_t py, word_t pz);
        hars_in_t it;
        it = '0;
        it.mode = MODE_HIT;
        it.sensor_id = sid;
        it.param_select = 4'($urandom);
        it.param_value = $urandom;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        send_item(it);
    endtask

    task automatic send_load(logic [7:0] sid, logic [3:0] sel, word_t value);
        hars_in_t it;
        it = '0;
        it.mode = MODE_LOAD;
        it.sensor_id = sid;
        it.param_select = sel;
        it.param_value = value;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        send_item(it);
    endtask

    // all twelve words in a row so a hit never sees a partly loaded sensor
    task automatic load_sensor(logic [7:0] sid, word_t w [12]);
        for (int i = 0; i < 12; i++)
            send_load(sid, 4'(i), w[i]);
    endtask

    function automatic word_t rand_pos();
        if ($urandom_range(3) == 0)
            return $urandom;
        return word_t'($urandom_range(131072000)) - 32'sd65536000;
    endfunction

    function automatic word_t rand_const(int sel);
        if ($urandom_range(7) == 0)
            return $urandom;
        if (sel == SEL_CA || sel == SEL_CB || sel == SEL_CG)
            return 32'sd65536 - word_t'($urandom_range(200));
        if (sel == SEL_SA || sel == SEL_SB || sel == SEL_SG)
            return word_t'($urandom_range(6000)) - 32'sd3000;
        return word_t'($urandom_range(20000000)) - 32'sd10000000;
    endfunction

    task automatic load_random_sensor(logic [7:0] sid);
        word_t w [12];
        for (int i = 0; i < 12; i++)
            w[i] = rand_const(i);
        load_sensor(sid, w);
    endtask

    // hits on sensors never loaded come back unchanged
    task automatic test_passthrough();
        send_hit(8'd7, 32'h7fffffff, 32'h80000000, 32'h00000000);
        send_hit(8'd255, 32'h80000000, 32'hffffffff, 32'h7fffffff);
        send_hit(8'd0, 32'h00000001, 32'h7fffffff, 32'h80000000);
    endtask

    // identity, extreme and ignored loads, each hit right after its load
    task automatic test_directed_align();
        word_t w [12];
        w = '{32'sd1000, -32'sd2000, 32'sd65536, 32'sd65536, 0, 32'sd65536, 0,
              32'sd65536, 0, 32'sd16, -32'sd16, 0};
        load_sensor(8'd255, w);
        send_hit(8'd255, 32'h12345678, 32'h80000000, 32'h7fffffff);
        w = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h7fffffff};
        load_sensor(8'd0, w);
        send_hit(8'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        // selects above the last word are dropped
        send_load(8'd200, 4'd12, 32'h55555555);
        send_load(8'd0, 4'd15, 32'h00000000);
        send_hit(8'd200, 32'h00010000, 32'h00020000, 32'h00030000);
    endtask

    // mostly hits on loaded sensors, some new sets, overwrites and noise
    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        int     pick;
        logic [7:0] sid;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            sid = 8'($urandom);
            if (pick < 4)
                load_random_sensor(sid);
            else if (pick < 10)
            begin
                if (known_sensor[sid])
                    send_load(sid, 4'($urandom_range(11)), rand_const(0));
                else
                    send_load(sid, 4'($urandom_range(15, 12)), $urandom);
            end
            else
            begin
                if (pick < 80)
                    for (int j = 0; j < 8 && !known_sensor[sid]; j++)
                        sid = 8'($urandom);
                send_hit(sid, rand_pos(), rand_pos(), rand_pos());
            end
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_left = 300;
        for (int n = 0; n < 40; n++)
            send_hit(8'($urandom), rand_pos(), rand_pos(), rand_pos());
    endtask

    // receiver: check each result transfer, then pick next stall
    always @(posedge clk)
    begin
        hars_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (hit_results_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result x=%h y=%h z=%h", result.out_x,
                             result.out_y, result.out_z);
            end
            else
            begin
                want = hit_results_q.pop_front();
                if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
                    result.out_z !== want.out_z || result.aligned !== want.aligned ||
                    result.saturated !== want.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("exp x=%h y=%h z=%h a=%b s=%b got x=%h y=%h z=%h a=%b s=%b",
                                 want.out_x, want.out_y, want.out_z, want.aligned,
                                 want.saturated, result.out_x, result.out_y,
                                 result.out_z, result.aligned, result.saturated);
                end
            end
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough();
        test_directed_align();
        for (int s = 0; s < 16; s++)
            load_random_sensor(8'($urandom));
        test_random(170, 0, 0);
        test_random(170, 68, 0);
        test_backpressure();
        test_random(170, 0, 68);
        test_random(170, 12, 12);
        item_valid <= 1'b0;
        while (hit_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && hit_results_q.size() == 0)
            $display("hit_alignment_rotate_shift_core test passed");
        else
            $display("hit_alignment_rotate_shift_core test failed");
        $finish;
    end

endmodule
